FILE: rtl/epd_pkg.sv
// shared types and byte constants for the escaped packet deframer
package epd_pkg;

    // link bytes with a special meaning
    localparam logic [7:0] MARK_BYTE   = 8'hFF;
    localparam logic [7:0] OPEN_BYTE   = 8'h7B;
    localparam logic [7:0] CLOSE_BYTE  = 8'h7D;
    localparam logic [7:0] BSLASH_BYTE = 8'h5C;
    localparam logic [7:0] X_BYTE      = 8'h78;

    // result kinds carried on tuser
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // output queue geometry
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // framing phase
    typedef enum logic [1:0] {
        PH_HUNT      = 2'd0,
        PH_HUNT_MARK = 2'd1,
        PH_IN        = 2'd2,
        PH_IN_MARK   = 2'd3
    } t_phase;

    // one result beat
    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    // results produced by one input byte
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_step;

endpackage

FILE: rtl/epd_step.sv
// next framing state and result beats for one received byte
module epd_step (
    input  epd_pkg::t_phase i_phase,
    input  logic            i_esc,
    input  logic [7:0]      i_byte,
    output epd_pkg::t_phase o_phase,
    output logic            o_esc,
    output epd_pkg::t_step  o_step
);
    import epd_pkg::*;

    // framing and unescape decisions
    always_comb begin
        o_phase          = i_phase;
        o_esc            = i_esc;
        o_step.num       = 2'd0;
        o_step.res0      = '{kind: KIND_DATA, data: i_byte, last: 1'b1};
        o_step.res1      = '{kind: KIND_DATA, data: i_byte, last: 1'b1};
        case (i_phase)
            PH_HUNT: begin
                if (i_byte == MARK_BYTE) begin
                    o_phase = PH_HUNT_MARK;
                end
            end
            PH_HUNT_MARK: begin
                if (i_byte == OPEN_BYTE) begin
                    o_phase = PH_IN;
                    o_esc   = 1'b0;
                end else if (i_byte != MARK_BYTE) begin
                    o_phase = PH_HUNT;
                end
            end
            PH_IN: begin
                if (i_byte == MARK_BYTE) begin
                    o_phase = PH_IN_MARK;
                end else if (i_esc) begin
                    // escape partner: x gives the marker byte, any other byte (backslash too) stays
                    o_esc      = 1'b0;
                    o_step.num = 2'd1;
                    if (i_byte == X_BYTE) begin
                        o_step.res0.data = MARK_BYTE;
                    end
                end else if (i_byte == BSLASH_BYTE) begin
                    o_esc = 1'b1;
                end else begin
                    o_step.num = 2'd1;
                end
            end
            PH_IN_MARK: begin
                // held marker byte always clears a pending escape
                o_esc = 1'b0;
                if (i_byte == CLOSE_BYTE) begin
                    o_step.num  = 2'd1;
                    o_step.res0 = '{kind: KIND_END, data: 8'h00, last: 1'b1};
                    o_phase     = PH_HUNT;
                end else if (i_byte == MARK_BYTE) begin
                    o_step.num       = 2'd1;
                    o_step.res0.data = MARK_BYTE;
                end else begin
                    o_phase          = PH_IN;
                    o_step.res0.data = MARK_BYTE;
                    if (i_byte == BSLASH_BYTE) begin
                        o_esc      = 1'b1;
                        o_step.num = 2'd1;
                    end else begin
                        o_step.num       = 2'd2;
                        o_step.res0.last = 1'b0;
                    end
                end
            end
            default: begin
                o_phase = PH_HUNT;
            end
        endcase
    end

endmodule

FILE: rtl/epd_outq.sv
// small result queue: up to two beats written per cycle, one read
module epd_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  epd_pkg::t_step  i_step,
    input  logic            i_push,
    output logic            o_room,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output epd_pkg::t_result o_head
);
    import epd_pkg::*;

    t_result             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic [QPTR_W-1:0]   n_wp;
    logic [QPTR_W-1:0]   n_rp;
    logic [QCNT_W-1:0]   n_cnt;
    logic [1:0]          push_num;
    logic                pop;

    // flow control: room for a worst-case pair of results
    assign o_room     = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));
    assign o_m_tvalid = (r_cnt != '0);
    assign o_head     = r_q[r_rp];
    assign pop        = o_m_tvalid && i_m_tready;
    assign push_num   = i_push ? i_step.num : 2'd0;

    // pointer and fill count update
    always_comb begin
        n_wp  = r_wp + QPTR_W'(push_num);
        n_rp  = r_rp + QPTR_W'(pop);
        n_cnt = r_cnt + QCNT_W'(push_num) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // entry writes
    always_ff @(posedge i_clk) begin
        if (push_num != 2'd0) begin
            r_q[r_wp] <= i_step.res0;
        end
        if (push_num == 2'd2) begin
            r_q[r_wp + QPTR_W'(1)] <= i_step.res1;
        end
    end

endmodule

FILE: rtl/escaped_packet_deframer.sv
// top level of the escaped packet deframer
// Takes one link byte per beat and emits decoded payload bytes and end-of-packet
// beats. A packet opens with 0xFF '{' and closes with 0xFF '}'; inside, \\ gives a
// backslash, \x gives 0xFF and a backslash before any other byte is dropped. The
// input takes one byte every cycle while the four-entry result queue holds at most
// two beats. A byte that yields two results (a held 0xFF released with the next
// byte) always ends a run of 0xFF bytes whose first yields none, so results never
// outnumber bytes and with a ready receiver the input runs at one byte per cycle;
// it stalls only while the receiver stalls and more than two beats wait. Results
// are registered in the queue before leaving. tlast marks the last result of a byte.
module escaped_packet_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] data
    output logic       o_m_tuser,   // [0] kind
    output logic       o_m_tlast
);
    import epd_pkg::*;

    t_phase  r_phase;
    logic    r_esc;
    t_phase  n_phase;
    logic    n_esc;
    t_step   step;
    t_result head;
    logic    accept;

    assign accept = i_s_tvalid && o_s_tready;

    // byte decode
    epd_step u_step (
        .i_phase (r_phase),
        .i_esc   (r_esc),
        .i_byte  (i_s_tdata),
        .o_phase (n_phase),
        .o_esc   (n_esc),
        .o_step  (step)
    );

    // framing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_esc   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_esc   <= n_esc;
        end
    end

    // result queue
    epd_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_push     (accept),
        .o_room     (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_head     (head)
    );

    assign o_m_tdata = head.data;
    assign o_m_tuser = head.kind;
    assign o_m_tlast = head.last;

endmodule

FILE: rtl/epd_checker.sv
// port-level checks for the escaped packet deframer
module epd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tuser,
    input logic       o_m_tlast
);
    import epd_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result beat changed while stalled");

    // an end beat is the only result of its byte and carries zero data
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_END) |-> o_m_tlast && (o_m_tdata == 8'h00))
        else $error("end beat malformed");

    // the first of a result pair is the released marker byte
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> (o_m_tuser == KIND_DATA) && (o_m_tdata == MARK_BYTE))
        else $error("unexpected first beat of a pair");

    // the second beat of a pair is already queued
    a_pair_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("second beat of a pair missing");

    // nothing to send and input ready right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid && o_s_tready)
        else $error("output not empty after reset");

endmodule

bind escaped_packet_deframer epd_checker u_epd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
